/* hw/rtl/gld_pkg.sv */
// shared constants, types and helpers of the gif lzw pixel decoder
`timescale 1ns / 1ps
package gld_pkg;
	localparam int MAX_CODE_BITS_DEF = 12;
	localparam int DICT_ENTRIES_DEF  = 4096;
	localparam int PIX_PER_RES       = 64;
	localparam int MAX_RESULTS       = 64;
	localparam int PIX_CAP           = MAX_RESULTS * PIX_PER_RES;
	localparam int PIX_CAP_END       = (MAX_RESULTS - 1) * PIX_PER_RES;
	localparam int CNT_W             = $clog2(PIX_PER_RES + 1);
	localparam int TOT_W             = $clog2(PIX_CAP + 1);
	localparam int SIZE_W            = 4;
	localparam logic [SIZE_W-1:0] MIN_SIZE_RESET = 4'd8;
	localparam logic [SIZE_W-1:0] MIN_SIZE_LO    = 4'd2;
	localparam logic [SIZE_W-1:0] MIN_SIZE_HI    = 4'd9;

	// one pixel beat from the decoder core
	typedef struct packed {
		logic       valid;
		logic [7:0] pixel;
	} pix_beat_t;

	// end of the work on one input byte
	typedef struct packed {
		logic valid;
		logic ended;
	} run_end_t;

	// packer answers to the core
	typedef struct packed {
		logic pix_ready;
		logic end_ready;
	} pack_ack_t;

	// clamp the minimum code size to the legal range
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] r;
		r = s;
		if (s < MIN_SIZE_LO) r = MIN_SIZE_LO;
		if (s > MIN_SIZE_HI) r = MIN_SIZE_HI;
		return r;
	endfunction
endpackage

/* hw/rtl/gld_channels.sv */
// stream channel interfaces of the gif lzw pixel decoder
`timescale 1ns / 1ps
interface gld_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	modport source(output valid, output stream_byte, input ready);
	modport sink(input valid, input stream_byte, output ready);
endinterface

interface gld_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] pixels_a;
	logic [63:0] pixels_b;
	logic [63:0] pixels_c;
	logic [63:0] pixels_d;
	logic [63:0] pixels_e;
	logic [63:0] pixels_f;
	logic [63:0] pixels_g;
	logic [63:0] pixels_h;
	logic [6:0]  pixel_count;
	logic        last_of_run;
	logic        end_of_image;
	modport source(output valid, output pixels_a, output pixels_b, output pixels_c,
		output pixels_d, output pixels_e, output pixels_f, output pixels_g,
		output pixels_h, output pixel_count, output last_of_run, output end_of_image,
		input ready);
	modport sink(input valid, input pixels_a, input pixels_b, input pixels_c,
		input pixels_d, input pixels_e, input pixels_f, input pixels_g,
		input pixels_h, input pixel_count, input last_of_run, input end_of_image,
		output ready);
endinterface

/* hw/rtl/gld_core.sv */
// framing, code unpacking, dictionary memory, chain walk and string stack
`timescale 1ns / 1ps
module gld_core #(
	parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF,
	parameter int DICT_ENTRIES  = gld_pkg::DICT_ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                in_byte,
	input  logic                      cfg_we,
	input  logic [gld_pkg::SIZE_W-1:0] cfg_wdata,
	output gld_pkg::pix_beat_t        pix,
	output gld_pkg::run_end_t         run_end,
	input  gld_pkg::pack_ack_t        ack
);
	localparam int CW     = MAX_CODE_BITS;
	localparam int ACC_W  = CW + 7;
	localparam int PEND_W = $clog2(ACC_W + 1);
	localparam int WID_W  = $clog2(CW + 1);
	localparam int SLOT_W = CW + 1;
	localparam int IDX_W  = $clog2(DICT_ENTRIES);
	localparam int DEP_W  = $clog2(DICT_ENTRIES + 1);
	localparam int ENT_W  = CW + 8;
	localparam logic [DEP_W-1:0] DEPTH_MAX = DEP_W'(DICT_ENTRIES);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_EXTRACT = 4'd1;
	localparam logic [3:0] ST_FIRST   = 4'd2;
	localparam logic [3:0] ST_WALK    = 4'd3;
	localparam logic [3:0] ST_WDATA   = 4'd4;
	localparam logic [3:0] ST_ROOT    = 4'd5;
	localparam logic [3:0] ST_POP     = 4'd6;
	localparam logic [3:0] ST_PWAIT   = 4'd7;
	localparam logic [3:0] ST_DONE    = 4'd8;

	logic [3:0]                 state_q;
	logic [gld_pkg::SIZE_W-1:0] min_q;
	logic [ACC_W-1:0]           acc_q;
	logic [PEND_W-1:0]          pend_q;
	logic [7:0]                 left_q;
	logic [WID_W-1:0]           width_q;
	logic [SLOT_W-1:0]          slot_q;
	logic [CW-1:0]              old_q;
	logic [7:0]                 first_q;
	logic                       expect_q;
	logic                       done_q;
	logic                       ended_q;
	logic [CW-1:0]              code_q;
	logic [CW-1:0]              cur_q;
	logic [DEP_W-1:0]           depth_q;

	logic [ENT_W-1:0] dict_mem [DICT_ENTRIES];
	logic [ENT_W-1:0] dict_rd_q;
	logic [7:0]       stack_mem [DICT_ENTRIES];
	logic [7:0]       stack_rd_q;

	logic [gld_pkg::SIZE_W-1:0] s_eff;
	logic [gld_pkg::SIZE_W-1:0] s_cfg;
	logic [SLOT_W-1:0] clr_code;
	logic [SLOT_W-1:0] eoi_code;
	logic [SLOT_W-1:0] base_code;
	logic [SLOT_W-1:0] slot_lim;
	logic [CW-1:0]     width_mask;
	logic [CW-1:0]     code_now;
	logic [SLOT_W-1:0] code_ext;
	logic              have_code;
	logic [CW-1:0]     rd_prefix;
	logic [7:0]        rd_suffix;
	logic              chain_more;
	logic              walk_more;
	logic [SLOT_W-1:0] slot_next;

	logic             dict_re;
	logic [IDX_W-1:0] dict_ra;
	logic             dict_we;
	logic [IDX_W-1:0] dict_wa;
	logic [ENT_W-1:0] dict_wd;
	logic             stk_we;
	logic [IDX_W-1:0] stk_wa;
	logic [7:0]       stk_wd;
	logic             stk_re;
	logic [IDX_W-1:0] stk_ra;
	logic [DEP_W-1:0] depth_dec;

	// code arithmetic for the current size and width
	always_comb begin
		s_eff      = gld_pkg::eff_size(min_q);
		s_cfg      = gld_pkg::eff_size(cfg_wdata);
		clr_code   = SLOT_W'(1) << s_eff;
		eoi_code   = clr_code + SLOT_W'(1);
		base_code  = clr_code + SLOT_W'(2);
		slot_lim   = SLOT_W'(1) << width_q;
		width_mask = CW'(slot_lim - SLOT_W'(1));
		code_now   = acc_q[CW-1:0] & width_mask;
		code_ext   = {1'b0, code_now};
		have_code  = pend_q >= PEND_W'(width_q);
		rd_prefix  = dict_rd_q[ENT_W-1:8];
		rd_suffix  = dict_rd_q[7:0];
		chain_more = ({1'b0, cur_q} >= base_code) && (depth_q < DEPTH_MAX);
		walk_more  = ({1'b0, rd_prefix} >= base_code) &&
			((depth_q + DEP_W'(1)) < DEPTH_MAX);
		slot_next  = (slot_q < slot_lim) ? slot_q + SLOT_W'(1) : slot_q;
		depth_dec  = depth_q - DEP_W'(1);
	end

	// memory port control
	always_comb begin
		dict_re = 1'b0;
		dict_ra = cur_q[IDX_W-1:0];
		dict_we = 1'b0;
		dict_wa = slot_q[IDX_W-1:0];
		dict_wd = {old_q, cur_q[7:0]};
		stk_we  = 1'b0;
		stk_wa  = depth_q[IDX_W-1:0];
		stk_wd  = rd_suffix;
		stk_re  = 1'b0;
		stk_ra  = depth_dec[IDX_W-1:0];
		case (state_q)
			ST_EXTRACT: begin
				if (have_code && code_ext != clr_code && code_ext != eoi_code &&
					!expect_q && code_ext >= slot_q) begin
					stk_we = 1'b1;
					stk_wa = '0;
					stk_wd = first_q;
				end
			end
			ST_WALK: begin
				dict_re = chain_more;
			end
			ST_WDATA: begin
				stk_we  = 1'b1;
				dict_re = walk_more;
				dict_ra = rd_prefix[IDX_W-1:0];
			end
			ST_ROOT: begin
				stk_we  = depth_q < DEPTH_MAX;
				stk_wd  = cur_q[7:0];
				dict_we = slot_q < slot_lim;
			end
			ST_POP: begin
				stk_re = depth_q != '0;
			end
			default: begin
			end
		endcase
	end

	// dictionary: prefix and suffix in one entry
	always_ff @(posedge clk) begin
		if (dict_we) dict_mem[dict_wa] <= dict_wd;
		if (dict_re) dict_rd_q <= dict_mem[dict_ra];
	end

	// string stack
	always_ff @(posedge clk) begin
		if (stk_we) stack_mem[stk_wa] <= stk_wd;
		if (stk_re) stack_rd_q <= stack_mem[stk_ra];
	end

	// handshake outputs
	always_comb begin
		in_ready      = state_q == ST_IDLE;
		pix.valid     = state_q == ST_FIRST || state_q == ST_PWAIT;
		pix.pixel     = (state_q == ST_FIRST) ? first_q : stack_rd_q;
		run_end.valid = state_q == ST_DONE;
		run_end.ended = ended_q;
	end

	// decoder sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			min_q    <= gld_pkg::MIN_SIZE_RESET;
			acc_q    <= '0;
			pend_q   <= '0;
			left_q   <= '0;
			width_q  <= WID_W'(gld_pkg::MIN_SIZE_RESET) + WID_W'(1);
			slot_q   <= (SLOT_W'(1) << gld_pkg::MIN_SIZE_RESET) + SLOT_W'(2);
			old_q    <= '0;
			first_q  <= '0;
			expect_q <= 1'b1;
			done_q   <= 1'b0;
			ended_q  <= 1'b0;
			code_q   <= '0;
			cur_q    <= '0;
			depth_q  <= '0;
		end else if (cfg_we) begin
			state_q  <= ST_IDLE;
			min_q    <= cfg_wdata;
			acc_q    <= '0;
			pend_q   <= '0;
			left_q   <= '0;
			width_q  <= WID_W'(s_cfg) + WID_W'(1);
			slot_q   <= (SLOT_W'(1) << s_cfg) + SLOT_W'(2);
			old_q    <= '0;
			first_q  <= '0;
			expect_q <= 1'b1;
			done_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !done_q) begin
						if (left_q == '0) begin
							if (in_byte == '0) begin
								done_q  <= 1'b1;
								ended_q <= 1'b1;
								state_q <= ST_DONE;
							end else begin
								left_q <= in_byte;
							end
						end else begin
							left_q  <= left_q - 8'd1;
							acc_q   <= acc_q | (ACC_W'(in_byte) << pend_q);
							pend_q  <= pend_q + PEND_W'(8);
							state_q <= ST_EXTRACT;
						end
					end
				end
				ST_EXTRACT: begin
					if (have_code) begin
						acc_q  <= acc_q >> width_q;
						pend_q <= pend_q - PEND_W'(width_q);
						if (code_ext == clr_code) begin
							width_q  <= WID_W'(s_eff) + WID_W'(1);
							slot_q   <= base_code;
							expect_q <= 1'b1;
						end else if (code_ext == eoi_code) begin
							done_q  <= 1'b1;
							ended_q <= 1'b1;
							state_q <= ST_DONE;
						end else if (expect_q) begin
							// out-of-range first code reads as zero
							old_q    <= (code_ext >= slot_q) ? '0 : code_now;
							first_q  <= (code_ext >= slot_q) ? 8'd0 : code_now[7:0];
							expect_q <= 1'b0;
							state_q  <= ST_FIRST;
						end else begin
							code_q  <= code_now;
							state_q <= ST_WALK;
							if (code_ext >= slot_q) begin
								// code not yet in the table: old string plus its head
								depth_q <= DEP_W'(1);
								cur_q   <= old_q;
							end else begin
								depth_q <= '0;
								cur_q   <= code_now;
							end
						end
					end else begin
						ended_q <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_FIRST: begin
					if (ack.pix_ready) state_q <= ST_EXTRACT;
				end
				ST_WALK: begin
					state_q <= chain_more ? ST_WDATA : ST_ROOT;
				end
				ST_WDATA: begin
					depth_q <= depth_q + DEP_W'(1);
					cur_q   <= rd_prefix;
					if (!walk_more) state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (depth_q < DEPTH_MAX) depth_q <= depth_q + DEP_W'(1);
					slot_q  <= slot_next;
					first_q <= cur_q[7:0];
					old_q   <= code_q;
					if (slot_next >= slot_lim && width_q < WID_W'(CW))
						width_q <= width_q + WID_W'(1);
					state_q <= ST_POP;
				end
				ST_POP: begin
					if (depth_q == '0) begin
						state_q <= ST_EXTRACT;
					end else begin
						depth_q <= depth_dec;
						state_q <= ST_PWAIT;
					end
				end
				ST_PWAIT: begin
					if (ack.pix_ready) state_q <= ST_POP;
				end
				ST_DONE: begin
					if (ack.end_ready) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

/* hw/rtl/gld_pack.sv */
// packs pixel beats into results of up to 64 pixels with an output register
`timescale 1ns / 1ps
module gld_pack (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  gld_pkg::pix_beat_t                    pix,
	input  gld_pkg::run_end_t                     run_end,
	output gld_pkg::pack_ack_t                    ack,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [gld_pkg::PIX_PER_RES*8-1:0]     out_pixels,
	output logic [gld_pkg::CNT_W-1:0]             out_count,
	output logic                                  out_last,
	output logic                                  out_eoi
);
	localparam int BUF_W = gld_pkg::PIX_PER_RES * 8;
	localparam int IX_W  = $clog2(gld_pkg::PIX_PER_RES);
	localparam logic [gld_pkg::CNT_W-1:0] FULL = gld_pkg::CNT_W'(gld_pkg::PIX_PER_RES);
	localparam logic [gld_pkg::TOT_W-1:0] CAP  = gld_pkg::TOT_W'(gld_pkg::PIX_CAP);
	localparam logic [gld_pkg::TOT_W-1:0] CAP_END = gld_pkg::TOT_W'(gld_pkg::PIX_CAP_END);

	localparam logic [2:0] ACT_NONE   = 3'd0;
	localparam logic [2:0] ACT_APPEND = 3'd1;
	localparam logic [2:0] ACT_START  = 3'd2;
	localparam logic [2:0] ACT_MARK   = 3'd3;
	localparam logic [2:0] ACT_FINISH = 3'd4;
	localparam logic [2:0] ACT_DROP   = 3'd5;

	logic [BUF_W-1:0]              buf_q;
	logic [gld_pkg::CNT_W-1:0]     bcnt_q;
	logic [gld_pkg::TOT_W-1:0]     total_q;
	logic                          mark_q;
	logic                          ov_q;
	logic [BUF_W-1:0]              opix_q;
	logic [gld_pkg::CNT_W-1:0]     ocnt_q;
	logic                          olast_q;
	logic                          oeoi_q;

	logic                          can_push;
	logic                          push;
	logic                          push_marker;
	logic                          push_last;
	logic [2:0]                    act;

	// beat decisions
	always_comb begin
		can_push    = !ov_q || out_ready;
		push        = 1'b0;
		push_marker = 1'b0;
		push_last   = 1'b0;
		act         = ACT_NONE;
		ack         = '0;
		if (pix.valid) begin
			if (total_q >= CAP) begin
				ack.pix_ready = 1'b1;
				act           = ACT_DROP;
			end else if (bcnt_q == FULL) begin
				if (can_push) begin
					push          = 1'b1;
					ack.pix_ready = 1'b1;
					act           = ACT_START;
				end
			end else begin
				ack.pix_ready = 1'b1;
				act           = ACT_APPEND;
			end
		end else if (run_end.valid) begin
			if (mark_q) begin
				if (can_push) begin
					push          = 1'b1;
					push_marker   = 1'b1;
					ack.end_ready = 1'b1;
					act           = ACT_FINISH;
				end
			end else if (bcnt_q != '0 && !(run_end.ended && total_q > CAP_END)) begin
				if (can_push) begin
					push      = 1'b1;
					push_last = !run_end.ended;
					if (run_end.ended) begin
						act = ACT_MARK;
					end else begin
						ack.end_ready = 1'b1;
						act           = ACT_FINISH;
					end
				end
			end else if (run_end.ended) begin
				// pixels past the cap give way to the end marker
				act = ACT_MARK;
			end else begin
				ack.end_ready = 1'b1;
				act           = ACT_FINISH;
			end
		end
	end

	// build buffer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q   <= '0;
			bcnt_q  <= '0;
			total_q <= '0;
			mark_q  <= 1'b0;
		end else begin
			case (act)
				ACT_APPEND: begin
					buf_q[bcnt_q[IX_W-1:0]*8 +: 8] <= pix.pixel;
					bcnt_q  <= bcnt_q + gld_pkg::CNT_W'(1);
					total_q <= total_q + gld_pkg::TOT_W'(1);
				end
				ACT_START: begin
					buf_q   <= BUF_W'(pix.pixel);
					bcnt_q  <= gld_pkg::CNT_W'(1);
					total_q <= total_q + gld_pkg::TOT_W'(1);
				end
				ACT_MARK: begin
					buf_q  <= '0;
					bcnt_q <= '0;
					mark_q <= 1'b1;
				end
				ACT_FINISH: begin
					buf_q   <= '0;
					bcnt_q  <= '0;
					total_q <= '0;
					mark_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (push) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			opix_q  <= push_marker ? '0 : buf_q;
			ocnt_q  <= push_marker ? '0 : bcnt_q;
			olast_q <= push_marker || push_last;
			oeoi_q  <= push_marker;
		end
	end

	assign out_valid  = ov_q;
	assign out_pixels = opix_q;
	assign out_count  = ocnt_q;
	assign out_last   = olast_q;
	assign out_eoi    = oeoi_q;
endmodule

/* hw/rtl/gif_lzw_pixel_decoder.sv */
// top level of the gif lzw pixel decoder
`timescale 1ns / 1ps
// Takes GIF image-data bytes (sub-block length bytes included) one beat at a
// time and returns the decoded pixels, up to 64 per result beat, with
// last_of_run on the final result of each byte and a zero-count end marker
// when the end code or a zero-length block arrives. Writing min_code_size
// starts a new image; the dictionary keeps its contents. A data byte is
// accepted only while the core is idle, and its codes are unpacked one by one;
// a first code gives its pixel directly, and a table code walks its chain
// through the dictionary memory and then pops its pixels from the string
// stack, so throughput is set by the length of the decoded strings and the
// memory reads. A stalled result beat holds the core. No clearing pass runs
// after reset.
module gif_lzw_pixel_decoder #(
	parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF,
	parameter int DICT_ENTRIES  = gld_pkg::DICT_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	gld_byte_if.sink                   in_ch,
	gld_result_if.source               out_ch,
	input  logic                       cfg_we,
	input  logic [gld_pkg::SIZE_W-1:0] cfg_wdata
);
	gld_pkg::pix_beat_t pix;
	gld_pkg::run_end_t  run_end;
	gld_pkg::pack_ack_t ack;
	logic [gld_pkg::PIX_PER_RES*8-1:0] pixels;

	// decoder core
	gld_core #(
		.MAX_CODE_BITS(MAX_CODE_BITS),
		.DICT_ENTRIES (DICT_ENTRIES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.in_byte  (in_ch.stream_byte),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.pix      (pix),
		.run_end  (run_end),
		.ack      (ack)
	);

	// result packer
	gld_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.run_end   (run_end),
		.ack       (ack),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_pixels(pixels),
		.out_count (out_ch.pixel_count),
		.out_last  (out_ch.last_of_run),
		.out_eoi   (out_ch.end_of_image)
	);

	// split pixel word into result fields
	assign out_ch.pixels_a = pixels[63:0];
	assign out_ch.pixels_b = pixels[127:64];
	assign out_ch.pixels_c = pixels[191:128];
	assign out_ch.pixels_d = pixels[255:192];
	assign out_ch.pixels_e = pixels[319:256];
	assign out_ch.pixels_f = pixels[383:320];
	assign out_ch.pixels_g = pixels[447:384];
	assign out_ch.pixels_h = pixels[511:448];
endmodule

/* hw/rtl/gld_checker.sv */
// port-level checks of the gif lzw pixel decoder and their bind
`timescale 1ns / 1ps
module gld_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_pixels_a,
	input logic [6:0]  out_count,
	input logic        out_last,
	input logic        out_eoi
);
	// a stalled beat stays
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// a stalled beat keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_count) && $stable(out_pixels_a) &&
			$stable(out_eoi))
		else $error("result payload changed while stalled");

	// end marker is empty and closes the run
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_eoi |-> out_count == 7'd0 && out_last)
		else $error("bad end marker");

	// pixel results carry between one and 64 pixels
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_eoi |-> out_count != 7'd0 && out_count <= 7'd64)
		else $error("bad pixel count");
endmodule

bind gif_lzw_pixel_decoder gld_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_pixels_a(out_ch.pixels_a),
	.out_count   (out_ch.pixel_count),
	.out_last    (out_ch.last_of_run),
	.out_eoi     (out_ch.end_of_image)
);

/* bench/gld_pixel_checker.sv */
// checker for the gif lzw pixel decoder: predicts pixel results and compares them
`timescale 1ns / 1ps
module gld_pixel_checker (
	input  logic       clk,
	input  logic       arst_n,
	gld_byte_if        in_ch,
	gld_result_if      out_ch,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	output int         pending,
	output int         errors
);
	typedef struct {
		logic [511:0] pixels;
		logic [6:0]   count;
		logic         last;
		logic         eoi;
	} pix_result_t;

	pix_result_t expected_results[$];

	// decoder state as the predictor sees it
	logic [11:0] prefix_mem [4096];
	logic [7:0]  suffix_mem [4096];
	logic [3:0]  size_reg;
	int unsigned acc, nbits, blk_left, width, slot, prev_code, first_pix;
	bit          want_first, done;
	byte unsigned pix_q[$];

	function automatic int unsigned clamp_size();
		int unsigned s;
		s = size_reg;
		if (s < 2) s = 2;
		if (s > 9) s = 9;
		return s;
	endfunction

	function automatic void restart_image();
		width = clamp_size() + 1;
		slot = (1 << clamp_size()) + 2;
		prev_code = 0;
		first_pix = 0;
		want_first = 1;
		done = 0;
		acc = 0;
		nbits = 0;
		blk_left = 0;
	endfunction

	function automatic void put_pixel(int unsigned p);
		if (pix_q.size() < 4096) pix_q.push_back(p[7:0]);
	endfunction

	// one code through the dictionary; returns one on the end code
	function automatic bit decode_code(int unsigned c);
		int unsigned s, clr, base, code, root;
		byte unsigned stk[$];
		s = clamp_size();
		clr = 1 << s;
		base = clr + 2;
		if (c == clr) begin
			width = s + 1;
			slot = base;
			want_first = 1;
			return 0;
		end
		if (c == clr + 1) begin
			done = 1;
			return 1;
		end
		if (want_first) begin
			if (c >= slot) c = 0;
			prev_code = c;
			first_pix = c & 8'hFF;
			want_first = 0;
			put_pixel(c);
			return 0;
		end
		code = c;
		// kwkwk and codes beyond the next slot repeat the old string
		if (code >= slot) begin
			stk.push_back(first_pix[7:0]);
			code = prev_code;
		end
		while (code >= base && stk.size() < 4096) begin
			stk.push_back(suffix_mem[code & 12'hFFF]);
			code = prefix_mem[code & 12'hFFF];
		end
		root = code & 8'hFF;
		if (stk.size() < 4096) stk.push_back(root[7:0]);
		if (slot < (1 << width)) begin
			suffix_mem[slot & 12'hFFF] = root[7:0];
			prefix_mem[slot & 12'hFFF] = prev_code[11:0];
			slot++;
		end
		first_pix = root;
		prev_code = c & 12'hFFF;
		if (slot >= (1 << width) && width < 12) width++;
		while (stk.size() > 0) put_pixel(stk.pop_back());
		return 0;
	endfunction

	// expected results of one accepted stream byte
	function automatic void decode_byte(logic [7:0] b);
		bit ended;
		int unsigned nres, total, n, cnt;
		pix_result_t r;
		ended = 0;
		if (done) return;
		pix_q.delete();
		if (blk_left == 0) begin
			if (b == 0) begin
				ended = 1;
				done = 1;
			end else begin
				blk_left = b;
			end
		end else begin
			blk_left--;
			acc |= int'(b) << nbits;
			nbits += 8;
			while (!ended && nbits >= width) begin
				int unsigned c;
				c = acc & ((1 << width) - 1);
				acc >>= width;
				nbits -= width;
				ended = decode_code(c);
			end
		end
		n = pix_q.size();
		if (ended && n > 63 * 64) n = 63 * 64;
		nres = (n + 63) / 64;
		total = nres + (ended ? 1 : 0);
		for (int k = 0; k < total; k++) begin
			r.pixels = '0;
			cnt = 0;
			if (k < nres) begin
				cnt = n - k * 64;
				if (cnt > 64) cnt = 64;
				for (int i = 0; i < cnt; i++) r.pixels[8*i +: 8] = pix_q[k*64 + i];
			end
			r.count = cnt[6:0];
			r.last = (k + 1 == total);
			r.eoi = (k >= nres);
			expected_results.push_back(r);
		end
	endfunction

	assign pending = expected_results.size();

	// predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_reg = 4'd8;
			restart_image();
			expected_results.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				size_reg = cfg_wdata;
				restart_image();
			end
			if (in_ch.valid && in_ch.ready) decode_byte(in_ch.stream_byte);
			if (out_ch.valid && out_ch.ready) begin
				logic [511:0] act;
				pix_result_t e;
				string names [8];
				names = '{"pixels_a", "pixels_b", "pixels_c", "pixels_d",
					"pixels_e", "pixels_f", "pixels_g", "pixels_h"};
				act = {out_ch.pixels_h, out_ch.pixels_g, out_ch.pixels_f, out_ch.pixels_e,
					out_ch.pixels_d, out_ch.pixels_c, out_ch.pixels_b, out_ch.pixels_a};
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					e = expected_results.pop_front();
					for (int i = 0; i < 8; i++) begin
						if (act[64*i +: 64] !== e.pixels[64*i +: 64]) begin
							$error("%s: expected %h, actual %h", names[i],
								e.pixels[64*i +: 64], act[64*i +: 64]);
							errors++;
						end
					end
					if (out_ch.pixel_count !== e.count) begin
						$error("pixel_count: expected %0d, actual %0d", e.count,
							out_ch.pixel_count);
						errors++;
					end
					if (out_ch.last_of_run !== e.last) begin
						$error("last_of_run: expected %0d, actual %0d", e.last,
							out_ch.last_of_run);
						errors++;
					end
					if (out_ch.end_of_image !== e.eoi) begin
						$error("end_of_image: expected %0d, actual %0d", e.eoi,
							out_ch.end_of_image);
						errors++;
					end
				end
			end
		end
	end
endmodule

/* bench/tb_top.sv */
// top of the gif lzw pixel decoder testbench: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_top;
	typedef enum int {END_CODE, END_BLOCK, END_NONE} img_end_t;

	localparam int CYCLE_LIMIT = 10000000;
	localparam int DRAIN_CYCLES = 100;
	localparam int PHASE_ITEMS = 35;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [3:0] cfg_wdata;
	int         pending;
	int         errors;
	int         send_pct;
	int         stall_pct;
	int         cycles = 0;
	int         hold_left = 0;
	logic       hold_req;
	logic       hold_q = 1'b0;
	byte unsigned img_q[$];

	gld_byte_if   byte_ch ();
	gld_result_if res_ch ();

	gif_lzw_pixel_decoder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(byte_ch),
		.out_ch(res_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	gld_pixel_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(byte_ch),
		.out_ch(res_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.pending(pending),
		.errors(errors)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result receiver with random stalls and one long hold-off
	always @(posedge clk) begin
		hold_q <= hold_req;
		if (hold_req && !hold_q) begin
			hold_left <= 600;
			res_ch.ready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_ch.ready <= 0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// one stream byte beat, with random idle cycles before it
	task automatic send_byte(input byte unsigned b);
		while ($urandom_range(99) < send_pct) begin
			byte_ch.valid <= 0;
			@(posedge clk);
		end
		byte_ch.valid <= 1;
		byte_ch.stream_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
	endtask

	// stop sending, wait for every result, let the core settle
	task automatic drain();
		byte_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input logic [3:0] v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// builds a framed code stream into img_q; calm leaves out clears and stray codes
	task automatic build_image(input logic [3:0] size_raw, input int ncodes,
		input img_end_t how, input bit calm);
		int unsigned s, clr, base, w, ns, c, r;
		bit first, force_clr;
		longint unsigned bits;
		int nb, pos, len;
		byte unsigned data[$];
		s = size_raw;
		if (s < 2) s = 2;
		if (s > 9) s = 9;
		clr = 1 << s;
		base = clr + 2;
		w = s + 1;
		ns = base;
		first = 1;
		force_clr = 0;
		bits = 0;
		nb = 0;
		img_q.delete();
		for (int k = 0; k <= ncodes; k++) begin
			r = $urandom_range(99);
			if (k == ncodes) begin
				if (how != END_CODE) break;
				c = clr + 1;
			end else if (force_clr || (!calm && r < 4)) begin
				c = clr;
				force_clr = 0;
			end else if (first) begin
				// a first code not below the next slot decodes as zero
				if (!calm && r < 12) c = $urandom_range((1 << w) - 1, base);
				else c = $urandom_range(clr - 1);
			end else if (!calm && r < 8 && ns + 1 < (1 << w)) begin
				c = $urandom_range((1 << w) - 1, ns + 1);
				force_clr = 1;
			end else if (r < 25 && ns < (1 << w)) begin
				c = ns;
			end else if (r < 70 && ns > base) begin
				c = $urandom_range(ns - 1, base);
			end else begin
				c = (r & 1) ? clr - 1 - $urandom_range(clr - 1) : $urandom_range(clr - 1);
			end
			bits |= longint'(c) << nb;
			nb += w;
			while (nb >= 8) begin
				data.push_back(bits[7:0]);
				bits >>= 8;
				nb -= 8;
			end
			// mirror of the width and slot growth
			if (c == clr) begin
				w = s + 1;
				ns = base;
				first = 1;
			end else if (c != clr + 1) begin
				if (first) begin
					first = 0;
				end else begin
					if (ns < (1 << w)) ns++;
					if (ns >= (1 << w) && w < 12) w++;
				end
			end
		end
		if (nb > 0) data.push_back(bits[7:0]);
		// sub-block framing, mostly short blocks
		pos = 0;
		while (pos < data.size()) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(255, 1) : $urandom_range(20, 1);
			if (len > data.size() - pos) len = data.size() - pos;
			img_q.push_back(len[7:0]);
			for (int i = 0; i < len; i++) img_q.push_back(data[pos + i]);
			pos += len;
		end
		if (how != END_NONE) img_q.push_back(8'd0);
		// bytes after the end are ignored
		if (how != END_NONE) repeat ($urandom_range(3)) img_q.push_back(8'($urandom_range(255)));
	endtask

	task automatic run_image(input logic [3:0] size_raw, input int ncodes,
		input img_end_t how, input bit calm);
		write_size(size_raw);
		build_image(size_raw, ncodes, how, calm);
		foreach (img_q[i]) send_byte(img_q[i]);
	endtask

	function automatic img_end_t pick_end();
		int r;
		r = $urandom_range(9);
		return (r < 6) ? END_CODE : (r < 9) ? END_BLOCK : END_NONE;
	endfunction

	initial begin
		int sent;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 4'd0;
		byte_ch.valid = 0;
		byte_ch.stream_byte = 8'd0;
		hold_req = 0;
		send_pct = 0;
		stall_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: decoding from reset with the reset size, then size extremes
		build_image(4'd8, 6, END_CODE, 0);
		foreach (img_q[i]) send_byte(img_q[i]);
		run_image(4'd2, 8, END_CODE, 0);
		run_image(4'd9, 6, END_BLOCK, 0);
		run_image(4'd0, 4, END_NONE, 0);
		run_image(4'd15, 4, END_CODE, 0);

		// steady stream with the code width growing several times
		run_image(4'd2, 40, END_CODE, 1);

		// random images in four idling phases
		for (int ph = 0; ph < 4; ph++) begin
			send_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 78 : 14) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 78 : 14) : 0;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				logic [3:0] sz;
				sz = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9, 2));
				write_size(sz);
				build_image(sz, $urandom_range(30, 3), pick_end(), 0);
				foreach (img_q[i]) begin
					if (sent >= PHASE_ITEMS) break;
					if (ph == 0 && sent == 10) hold_req <= 1;
					// pause the stream until every result is back
					if (ph == 0 && sent == 30) begin
						byte_ch.valid <= 0;
						@(posedge clk);
						while (pending != 0) @(posedge clk);
					end
					send_byte(img_q[i]);
					sent++;
				end
			end
		end

		drain();
		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule

/* sim.f */
hw/rtl/gld_pkg.sv
hw/rtl/gld_channels.sv
hw/rtl/gld_core.sv
hw/rtl/gld_pack.sv
hw/rtl/gif_lzw_pixel_decoder.sv
hw/rtl/gld_checker.sv
bench/gld_pixel_checker.sv
bench/tb_top.sv
